>>> rtl/kert_pkg.sv
// ----------------------------------------------------------------------------
// kert_pkg
// shared types and constants of the keyed event rate threshold block
// ----------------------------------------------------------------------------
package kert_pkg;

  localparam int KEY_ID_W   = 6;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [KEY_ID_W-1:0]   key_id_t;
  typedef logic [TIME_W-1:0]     time_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // operation codes
  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // configuration register indexes
  localparam cfg_idx_t REG_TRIGGER_COUNT  = 2'd0;
  localparam cfg_idx_t REG_TRIGGER_PERIOD = 2'd1;
  localparam cfg_idx_t REG_RESET_COUNT    = 2'd2;
  localparam cfg_idx_t REG_RESET_PERIOD   = 2'd3;

endpackage

>>> rtl/kert_in_if.sv
// ----------------------------------------------------------------------------
// kert_in_if
// input channel: one event or status check per transaction
// ----------------------------------------------------------------------------
interface kert_in_if;
  logic                valid;
  logic                ready;
  logic                op;
  kert_pkg::key_id_t   key_id;
  kert_pkg::time_t     now_time;

  modport source (output valid, op, key_id, now_time, input ready);
  modport sink   (input valid, op, key_id, now_time, output ready);
endinterface

>>> rtl/kert_out_if.sv
// ----------------------------------------------------------------------------
// kert_out_if
// result channel: trigger and reset flags, one transaction per input
// ----------------------------------------------------------------------------
interface kert_out_if;
  logic valid;
  logic ready;
  logic trigger_fired;
  logic reset_fired;

  modport source (output valid, trigger_fired, reset_fired, input ready);
  modport sink   (input valid, trigger_fired, reset_fired, output ready);
endinterface

>>> rtl/kert_ram.sv
// ----------------------------------------------------------------------------
// kert_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module kert_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/keyed_event_rate_threshold.sv
// ----------------------------------------------------------------------------
// keyed_event_rate_threshold
// per key sliding window event rate trigger with timed reset
// ----------------------------------------------------------------------------
// channel  dir  handshake       payload
// in_ch    in   valid / ready   op, key_id, now_time
// out_ch   out  valid / ready   trigger_fired, reset_fired
// cfg      in   cfg_we          cfg_index, cfg_data
//
// an item passes through accept, key state read, stamp read, compare and write back
// one subtract and compare unit serves both the trigger and the reset test
// after reset a clearing pass zeroes every entry of the key state ram
// a finished result sits in the output register; the next item may enter meanwhile
// the write back stalls only while a previous result is still untaken
// ----------------------------------------------------------------------------
module keyed_event_rate_threshold #(
  parameter int NUM_KEYS   = 64,
  parameter int RING_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  kert_in_if.sink               in_ch,
  kert_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  kert_pkg::cfg_idx_t    cfg_index,
  input  kert_pkg::cfg_data_t   cfg_data
);

  localparam int KEY_W       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int RING_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W      = $clog2(RING_DEPTH + 1);
  localparam int CNT_W       = (FILL_W > kert_pkg::COUNT_W) ? FILL_W : kert_pkg::COUNT_W;
  localparam int SUM_W       = RING_W + 2;
  localparam int META_W      = RING_W + FILL_W + 1;
  localparam int STAMP_DEPTH = NUM_KEYS * RING_DEPTH;
  localparam int ADDR_W      = (STAMP_DEPTH > 1) ? $clog2(STAMP_DEPTH) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_META  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [KEY_W-1:0] clr_r;

  kert_pkg::count_t trigger_count_r;
  kert_pkg::time_t  trigger_period_r;
  kert_pkg::count_t reset_count_r;
  kert_pkg::time_t  reset_period_r;

  logic             op_r;
  logic [KEY_W-1:0] key_r;
  kert_pkg::time_t  now_r;
  logic             key_ok_r;

  logic [RING_W-1:0] head_r;
  logic [FILL_W-1:0] fill_r;
  logic              trig_r;
  logic              check_r;
  logic [RING_W-1:0] slot_r;

  logic out_valid_r, out_trig_r, out_reset_r;

  logic                in_acc, in_key_ok, out_free, leave_cmp, is_event;
  logic [META_W-1:0]   meta_rdata, meta_wdata;
  logic                meta_we, meta_re;
  logic [KEY_W-1:0]    meta_waddr;
  logic [RING_W-1:0]   m_head, head_inc, head_use, slot;
  logic [FILL_W-1:0]   m_fill, fill_inc, fill_use;
  logic                m_trig, trig_chk, rst_chk, check;
  logic [CNT_W-1:0]    tc, fill_c, rk, rk_sel, k;
  logic [SUM_W-1:0]    slot_sum;
  logic [ADDR_W-1:0]   st_addr;
  logic                st_we, st_re;
  kert_pkg::time_t     st_rdata, elapsed, limit;
  logic                lt, hit, fired, trig_nxt;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && (state_r == S_IDLE);
  assign in_key_ok   = 32'(in_ch.key_id) < 32'(NUM_KEYS);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign leave_cmp   = (state_r == S_CMP) && out_free;
  assign is_event    = (op_r == kert_pkg::OP_EVENT);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == KEY_W'(NUM_KEYS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_META;
        end
      end
      S_META:  state_nxt = S_READ;
      S_READ:  state_nxt = S_CMP;
      S_CMP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_count_r  <= '0;
      trigger_period_r <= '0;
      reset_count_r    <= '0;
      reset_period_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        kert_pkg::REG_TRIGGER_COUNT:  trigger_count_r  <= cfg_data[kert_pkg::COUNT_W-1:0];
        kert_pkg::REG_TRIGGER_PERIOD: trigger_period_r <= cfg_data[kert_pkg::TIME_W-1:0];
        kert_pkg::REG_RESET_COUNT:    reset_count_r    <= cfg_data[kert_pkg::COUNT_W-1:0];
        kert_pkg::REG_RESET_PERIOD:   reset_period_r   <= cfg_data[kert_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_ch.op;
      key_r    <= KEY_W'(in_ch.key_id);
      now_r    <= in_ch.now_time;
      key_ok_r <= in_key_ok;
    end
  end

  // key state: head, fill, triggered
  assign meta_re    = in_acc && in_key_ok;
  assign meta_we    = (state_r == S_CLEAR) || (leave_cmp && key_ok_r);
  assign meta_waddr = (state_r == S_CLEAR) ? clr_r : key_r;
  assign meta_wdata = (state_r == S_CLEAR) ? '0 : {head_r, fill_r, trig_nxt};

  kert_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_KEYS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (KEY_W'(in_ch.key_id)),
    .rdata (meta_rdata)
  );

  assign m_head = meta_rdata[META_W-1 -: RING_W];
  assign m_fill = meta_rdata[FILL_W:1];
  assign m_trig = meta_rdata[0];

  always_comb begin
    head_inc = (m_head == RING_W'(RING_DEPTH - 1)) ? '0 : m_head + 1'b1;
    fill_inc = (m_fill < FILL_W'(RING_DEPTH)) ? m_fill + 1'b1 : m_fill;
    head_use = is_event ? head_inc : m_head;
    fill_use = is_event ? fill_inc : m_fill;
    tc       = CNT_W'(trigger_count_r);
    fill_c   = CNT_W'(fill_use);
    trig_chk = !m_trig && (tc != '0) && (trigger_period_r != '0) &&
               (tc <= CNT_W'(RING_DEPTH)) && (fill_c >= tc);
    rk       = (reset_count_r == '0) ? CNT_W'(1) : CNT_W'(reset_count_r);
    rk_sel   = (rk > fill_c) ? fill_c : rk;
    rst_chk  = m_trig && (fill_use != '0);
    k        = is_event ? tc : rk_sel;
    check    = key_ok_r && (is_event ? trig_chk : rst_chk);
    // slot of the k-th newest stamp
    slot_sum = SUM_W'(head_use) + SUM_W'(RING_DEPTH) - SUM_W'(k);
    if (slot_sum >= SUM_W'(RING_DEPTH)) begin
      slot = RING_W'(slot_sum - SUM_W'(RING_DEPTH));
    end else begin
      slot = RING_W'(slot_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_META) begin
      head_r  <= head_use;
      fill_r  <= fill_use;
      trig_r  <= m_trig;
      check_r <= check;
      slot_r  <= slot;
    end
  end

  // timestamp rings
  assign st_addr = ADDR_W'(key_r) * ADDR_W'(RING_DEPTH) +
                   ADDR_W'((state_r == S_META) ? m_head : slot_r);
  assign st_we   = (state_r == S_META) && key_ok_r && is_event;
  assign st_re   = (state_r == S_READ) && check_r;

  kert_ram #(
    .WIDTH (kert_pkg::TIME_W),
    .DEPTH (STAMP_DEPTH)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_addr),
    .wdata (now_r),
    .re    (st_re),
    .raddr (st_addr),
    .rdata (st_rdata)
  );

  // shared subtract and compare
  always_comb begin
    elapsed  = now_r - st_rdata;
    limit    = is_event ? trigger_period_r : reset_period_r;
    lt       = elapsed < limit;
    hit      = is_event ? (lt || (elapsed == limit)) : !lt;
    fired    = check_r && hit;
    trig_nxt = is_event ? (trig_r || fired) : (trig_r && !fired);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (leave_cmp) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (leave_cmp) begin
      out_trig_r  <= is_event && fired;
      out_reset_r <= !is_event && fired;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.trigger_fired = out_trig_r;
  assign out_ch.reset_fired   = out_reset_r;

endmodule

>>> tb/sv/keyed_event_rate_threshold_test.sv
// ----------------------------------------------------------------------------
// keyed_event_rate_threshold_test
// self-checking bench for the per key event rate trigger: a driver takes
// events and status checks from a queue, a predictor keeps its own copy of
// the stamp rings and trigger flags and works out the flags each transaction
// should return, and a monitor compares every result in order. the run steps
// through a series of register settings, extremes among them, with random
// idling on both channels and one long receiver hold-off
// ----------------------------------------------------------------------------
module keyed_event_rate_threshold_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_KEYS        = 64;
  localparam int RING_DEPTH      = 16;
  localparam int NUM_PHASES      = 11;
  localparam int ITEMS_PER_PHASE = 58;
  localparam int HOLD_PHASE      = 4;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 10;
  localparam int STALL_LIMIT     = 3000;

  typedef struct packed {
    logic              op;
    kert_pkg::key_id_t key_id;
    kert_pkg::time_t   now_time;
  } key_event_t;

  typedef struct packed {
    logic trigger_fired;
    logic reset_fired;
  } rate_flags_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  kert_pkg::cfg_idx_t  cfg_index = kert_pkg::REG_TRIGGER_COUNT;
  kert_pkg::cfg_data_t cfg_data = '0;

  kert_in_if  in_if ();
  kert_out_if out_if ();

  keyed_event_rate_threshold uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  kert_pkg::count_t win_count;
  kert_pkg::time_t  win_period;
  kert_pkg::count_t clear_count;
  kert_pkg::time_t  clear_period;
  kert_pkg::time_t  stamps [NUM_KEYS][RING_DEPTH];
  logic [3:0]       ring_pos [NUM_KEYS];
  kert_pkg::count_t fill [NUM_KEYS];
  logic             fired_flag [NUM_KEYS];

  key_event_t  pending_events [$];
  rate_flags_t expected_flags [$];

  int                mismatches = 0;
  int                stall_cycles = 0;
  int                phase_idx = 0;
  int                time_tick = 4;
  kert_pkg::time_t   clock_now;
  kert_pkg::key_id_t hot_keys [3];
  logic              hold_out = 1'b0;
  int                in_gap = 0;
  int                in_steady = 0;
  int                out_gap = 0;
  int                out_steady = 0;

  function automatic int pick_gap(inout int steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady > 0) begin
      steady--;
      return 0;
    end
    if (r < 3)
      steady = $urandom_range(10, 40);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic kert_pkg::time_t nth_newest_stamp(kert_pkg::key_id_t key, int k);
    return stamps[key][4'(ring_pos[key] - k)];
  endfunction

  function automatic rate_flags_t rate_window_predict(logic op, kert_pkg::key_id_t key,
                                                      kert_pkg::time_t now);
    rate_flags_t     res;
    int              k;
    kert_pkg::time_t elapsed;
    res = '0;
    if (op == kert_pkg::OP_EVENT) begin
      stamps[key][ring_pos[key]] = now;
      ring_pos[key] = ring_pos[key] + 4'd1;
      if (fill[key] < RING_DEPTH)
        fill[key] = fill[key] + 5'd1;
      if (!fired_flag[key] && win_count > 0 && win_period > 0 &&
          win_count <= RING_DEPTH && fill[key] >= win_count) begin
        elapsed = now - nth_newest_stamp(key, win_count);
        if (elapsed <= win_period) begin
          fired_flag[key] = 1'b1;
          res.trigger_fired = 1'b1;
        end
      end
    end else if (fired_flag[key] && fill[key] > 0) begin
      k = (clear_count == 0) ? 1 : clear_count;
      if (k > fill[key])
        k = fill[key];
      elapsed = now - nth_newest_stamp(key, k);
      if (elapsed >= clear_period) begin
        fired_flag[key] = 1'b0;
        res.reset_fired = 1'b1;
      end
    end
    return res;
  endfunction

  // driver
  always @(posedge clk) begin : drive
    key_event_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_flags.push_back(rate_window_predict(in_if.op, in_if.key_id, in_if.now_time));
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_if.valid <= 1'b0;
          in_gap--;
        end else if (pending_events.size() > 0) begin
          nxt = pending_events.pop_front();
          in_if.valid    <= 1'b1;
          in_if.op       <= nxt.op;
          in_if.key_id   <= nxt.key_id;
          in_if.now_time <= nxt.now_time;
          in_gap = pick_gap(in_steady);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin : watch
    rate_flags_t exp_f;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_flags.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: trigger %0b reset %0b",
                     out_if.trigger_fired, out_if.reset_fired);
        end else begin
          exp_f = expected_flags.pop_front();
          if (out_if.trigger_fired !== exp_f.trigger_fired ||
              out_if.reset_fired !== exp_f.reset_fired) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected trigger %0b reset %0b, got trigger %0b reset %0b",
                       exp_f.trigger_fired, exp_f.reset_fired,
                       out_if.trigger_fired, out_if.reset_fired);
          end
        end
      end
      if (hold_out) begin
        out_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_if.ready <= 1'b0;
        out_gap--;
      end else begin
        out_if.ready <= 1'b1;
        out_gap = pick_gap(out_steady);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (phase_idx == HOLD_PHASE);
    repeat (3) @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  task automatic write_reg(input kert_pkg::cfg_idx_t idx, input kert_pkg::cfg_data_t data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      kert_pkg::REG_TRIGGER_COUNT:  win_count    = kert_pkg::count_t'(data);
      kert_pkg::REG_TRIGGER_PERIOD: win_period   = data;
      kert_pkg::REG_RESET_COUNT:    clear_count  = kert_pkg::count_t'(data);
      kert_pkg::REG_RESET_PERIOD:   clear_period = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_phase(input int idx);
    kert_pkg::cfg_data_t v [4];
    case (idx)
      1: begin v = '{32'd3, 32'd10, 32'd1, 32'd20}; time_tick = 4; end
      2: begin v = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0}; time_tick = 1000; end
      3: begin v = '{32'd16, 32'd200, 32'd16, 32'hFFFF_FFFF}; time_tick = 8; end
      4: begin v = '{32'hFFFF_FFF1, 32'd50, 32'd31, 32'd5}; time_tick = 3; end
      5: begin v = '{32'h0000_0024, 32'd30, 32'hFFFF_FFE2, 32'd40}; time_tick = 6; end
      6: begin v = '{32'd0, 32'd100, 32'd3, 32'd1}; time_tick = 5; end
      7: begin v = '{32'd2, 32'd0, 32'd4, 32'd10}; time_tick = 5; end
      default: begin
        v = '{{27'($urandom()), 5'($urandom_range(1, RING_DEPTH))},
              32'($urandom_range(1, 200)),
              32'($urandom_range(0, RING_DEPTH + 1)),
              32'($urandom_range(0, 300))};
        time_tick = $urandom_range(1, 20);
      end
    endcase
    write_reg(kert_pkg::REG_TRIGGER_COUNT, v[0]);
    write_reg(kert_pkg::REG_TRIGGER_PERIOD, v[1]);
    write_reg(kert_pkg::REG_RESET_COUNT, v[2]);
    write_reg(kert_pkg::REG_RESET_PERIOD, v[3]);
  endtask

  task automatic push_item(input logic op, input kert_pkg::key_id_t key,
                           input kert_pkg::time_t now);
    pending_events.push_back('{op: op, key_id: key, now_time: now});
  endtask

  // trigger across the time wrap, window edge, reset measured across the wrap,
  // check on an unseen key, too few events for the window
  task automatic queue_directed();
    push_item(kert_pkg::OP_CHECK, 6'd5,  32'd0);
    push_item(kert_pkg::OP_EVENT, 6'd0,  32'hFFFF_FFF8);
    push_item(kert_pkg::OP_EVENT, 6'd0,  32'hFFFF_FFFC);
    push_item(kert_pkg::OP_CHECK, 6'd0,  32'hFFFF_FFFD);
    push_item(kert_pkg::OP_EVENT, 6'd0,  32'd1);
    push_item(kert_pkg::OP_EVENT, 6'd0,  32'd2);
    push_item(kert_pkg::OP_CHECK, 6'd0,  32'd21);
    push_item(kert_pkg::OP_CHECK, 6'd0,  32'd22);
    push_item(kert_pkg::OP_EVENT, 6'd63, 32'hFFFF_FFFF);
    push_item(kert_pkg::OP_EVENT, 6'd63, 32'hFFFF_FFFF);
    push_item(kert_pkg::OP_EVENT, 6'd63, 32'd8);
    push_item(kert_pkg::OP_CHECK, 6'd63, 32'd0);
    push_item(kert_pkg::OP_EVENT, 6'd1,  32'd100);
    push_item(kert_pkg::OP_EVENT, 6'd1,  32'd105);
    push_item(kert_pkg::OP_EVENT, 6'd1,  32'd110);
    push_item(kert_pkg::OP_CHECK, 6'd1,  32'd129);
  endtask

  // mostly bursts on a few busy keys with a slowly moving clock, some noise
  task automatic queue_random(input int count);
    logic              op;
    kert_pkg::key_id_t key;
    kert_pkg::time_t   now;
    foreach (hot_keys[i])
      hot_keys[i] = kert_pkg::key_id_t'($urandom_range(0, NUM_KEYS - 1));
    clock_now = $urandom();
    repeat (count) begin
      if ($urandom_range(0, 99) < 85) begin
        key = hot_keys[$urandom_range(0, 2)];
        op = ($urandom_range(0, 99) < 65) ? kert_pkg::OP_EVENT : kert_pkg::OP_CHECK;
        clock_now = clock_now + kert_pkg::time_t'($urandom_range(0, time_tick));
        if ($urandom_range(0, 9) == 0)
          clock_now = clock_now + kert_pkg::time_t'($urandom_range(0, 40 * time_tick));
        now = clock_now;
      end else begin
        key = kert_pkg::key_id_t'($urandom_range(0, NUM_KEYS - 1));
        op = ($urandom_range(0, 1) == 0) ? kert_pkg::OP_EVENT : kert_pkg::OP_CHECK;
        now = $urandom();
      end
      push_item(op, key, now);
    end
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_if.valid || expected_flags.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    win_count    = '0;
    win_period   = '0;
    clear_count  = '0;
    clear_period = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      ring_pos[k]   = '0;
      fill[k]       = '0;
      fired_flag[k] = 1'b0;
      for (int s = 0; s < RING_DEPTH; s++)
        stamps[k][s] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      phase_idx = ph;
      if (ph > 0)
        program_phase(ph);
      if (ph == 1)
        queue_directed();
      queue_random(ITEMS_PER_PHASE);
      wait_idle();
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> keyed_event_rate_threshold.f
rtl/kert_pkg.sv
rtl/kert_in_if.sv
rtl/kert_out_if.sv
rtl/kert_ram.sv
rtl/keyed_event_rate_threshold.sv
tb/sv/keyed_event_rate_threshold_test.sv
